// ----- src/sctfc_pkg.sv -----
// ----------------------------------------------------------------------------
// SSH channel table package
// Shared constants, codes and command/status types of the channel table.
// ----------------------------------------------------------------------------
package sctfc_pkg;

  localparam int unsigned NumChannels = 16;
  localparam int unsigned IdxW        = $clog2(NumChannels);
  localparam int unsigned CntW        = $clog2(NumChannels + 1);
  localparam logic [32:0] PktOverhead = 33'd5;
  localparam logic [31:0] DefWindowReset = 32'd32768;
  localparam logic [31:0] DefMaxPktReset = 32'd65536;

  // Entry states
  localparam logic [2:0] EST_FREE    = 3'd0;
  localparam logic [2:0] EST_ALLOC   = 3'd1;
  localparam logic [2:0] EST_PENDING = 3'd2;
  localparam logic [2:0] EST_INREPLY = 3'd3;
  localparam logic [2:0] EST_OPEN    = 3'd4;
  localparam logic [2:0] EST_CLOSED  = 3'd5;

  // Request codes
  localparam logic [3:0] FN_L_OPEN   = 4'd0;
  localparam logic [3:0] FN_L_WRITE  = 4'd1;
  localparam logic [3:0] FN_L_ADJUST = 4'd2;
  localparam logic [3:0] FN_L_EOF    = 4'd3;
  localparam logic [3:0] FN_L_CLOSE  = 4'd4;
  localparam logic [3:0] FN_R_OPEN   = 4'd5;
  localparam logic [3:0] FN_R_CONF   = 4'd6;
  localparam logic [3:0] FN_R_FAIL   = 4'd7;
  localparam logic [3:0] FN_R_ADJUST = 4'd8;
  localparam logic [3:0] FN_R_DATA   = 4'd9;
  localparam logic [3:0] FN_R_EOF    = 4'd10;
  localparam logic [3:0] FN_R_CLOSE  = 4'd11;

  // Result status
  localparam logic [2:0] RS_OK      = 3'd0;
  localparam logic [2:0] RS_INVAL   = 3'd1;
  localparam logic [2:0] RS_LARGE   = 3'd2;
  localparam logic [2:0] RS_FULL    = 3'd3;
  localparam logic [2:0] RS_IGNORED = 3'd4;

  // Actions
  localparam logic [3:0] AC_NONE         = 4'd0;
  localparam logic [3:0] AC_SEND_OPEN    = 4'd1;
  localparam logic [3:0] AC_SEND_CONFIRM = 4'd2;
  localparam logic [3:0] AC_SEND_FAIL    = 4'd3;
  localparam logic [3:0] AC_SEND_ADJUST  = 4'd4;
  localparam logic [3:0] AC_SEND_DATA    = 4'd5;
  localparam logic [3:0] AC_SEND_EOF     = 4'd6;
  localparam logic [3:0] AC_SEND_CLOSE   = 4'd7;
  localparam logic [3:0] AC_NOTE_OPEN    = 4'd8;
  localparam logic [3:0] AC_NOTE_WINDOW  = 4'd9;
  localparam logic [3:0] AC_NOTE_DATA    = 4'd10;
  localparam logic [3:0] AC_NOTE_EOF     = 4'd11;
  localparam logic [3:0] AC_NOTE_CLOSE   = 4'd12;

  localparam logic [31:0] REASON_PROHIBITED   = 32'd1;
  localparam logic [31:0] REASON_UNKNOWN_TYPE = 32'd3;
  localparam logic [31:0] REASON_SHORTAGE     = 32'd4;

  // Configuration register indexes
  localparam logic [0:0] CFG_DEF_WINDOW  = 1'b0;
  localparam logic [0:0] CFG_DEF_MAX_PKT = 1'b1;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] chan_id;
    logic [31:0] peer_id;
    logic [31:0] window;
    logic [31:0] max_packet;
    logic [31:0] amount;
    logic        type_known;
    logic        accepted;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  action;
    logic [7:0]  local_id;
    logic [31:0] remote_id;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic        last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;  // capture the request and scan the table
    logic read_ent;  // read the entry's memory words
    logic execute;   // compute results and update the entry
    logic sel_second;// present the second result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic two_results;
  } dp_sts_t;

endpackage

// ----- src/sctfc_datapath.sv -----
// ----------------------------------------------------------------------------
// SSH channel table datapath
// Holds the channel table, the free-entry search and the request decoder.
// ----------------------------------------------------------------------------
module sctfc_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sctfc_pkg::req_t           req_i,
  input  sctfc_pkg::dp_cmd_t        cmd_i,
  output sctfc_pkg::dp_sts_t        sts_o,
  output sctfc_pkg::res_t           res_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [31:0]               cfg_data_i
);
  import sctfc_pkg::*;

  logic [2:0]  state_q [NumChannels];
  logic [NumChannels-1:0] peof_q, leof_q;
  logic [CntW-1:0] used_q;
  logic [31:0] defwin_q, defpkt_q;

  // Per-entry words live in memories with registered reads.
  logic [31:0] lwin_mem [NumChannels];
  logic [31:0] lpkt_mem [NumChannels];
  logic [31:0] pnum_mem [NumChannels];
  logic [31:0] pwin_mem [NumChannels];
  logic [31:0] ppkt_mem [NumChannels];
  logic [31:0] lwin_rd_q, lpkt_rd_q, pnum_rd_q, pwin_rd_q, ppkt_rd_q;

  req_t            req_q;
  logic [IdxW-1:0] free_idx_q;
  logic            free_ok_q;
  logic            hit_q;
  logic [IdxW-1:0] idx_q;
  res_t            res0_q, res1_q;
  logic            two_q;

  // Lowest free entry
  logic [IdxW-1:0] free_idx_d;
  logic            free_ok_d;
  always_comb begin
    free_idx_d = '0;
    free_ok_d  = 1'b0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (state_q[i] == EST_FREE) begin
        free_idx_d = IdxW'(i);
        free_ok_d  = 1'b1;
      end
    end
  end

  logic            hit_d;
  logic [IdxW-1:0] idx_d;
  always_comb begin
    hit_d = (req_i.chan_id < 32'(NumChannels));
    idx_d = req_i.chan_id[IdxW-1:0];
  end

  // Index of the entry to read: allocation target for opens, else lookup.
  logic [IdxW-1:0] ent;
  assign ent = (req_q.func == FN_L_OPEN || req_q.func == FN_R_OPEN) ? free_idx_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q      <= req_i;
      free_idx_q <= free_idx_d;
      idx_q      <= idx_d;
    end
    if (cmd_i.read_ent) begin
      lwin_rd_q <= lwin_mem[ent];
      lpkt_rd_q <= lpkt_mem[ent];
      pnum_rd_q <= pnum_mem[ent];
      pwin_rd_q <= pwin_mem[ent];
      ppkt_rd_q <= ppkt_mem[ent];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
    end else if (cmd_i.load_req) begin
      hit_q     <= hit_d && (state_q[idx_d] != EST_FREE);
      free_ok_q <= free_ok_d;
    end
  end

  // Execute: decode and decide
  logic [2:0] st;
  logic [32:0] need;
  logic oc;
  res_t r0, r1;
  logic two;
  logic       wr_state, wr_lwin, wr_lpkt, wr_peer, wr_pwin, set_peof, set_leof;
  logic [2:0] new_state;
  logic [31:0] lwin_d, lpkt_d, pwin_d;
  logic inc_used, dec_used;
  logic [7:0] eid;
  always_comb begin
    st   = state_q[ent];
    need = {1'b0, req_q.amount} + PktOverhead;
    oc   = (st == EST_OPEN) || (st == EST_CLOSED);
    eid  = 8'(ent);
    r0 = '0; r1 = '0; two = 1'b0;
    wr_state = 1'b0; new_state = st;
    wr_lwin = 1'b0; wr_lpkt = 1'b0; wr_peer = 1'b0; wr_pwin = 1'b0;
    set_peof = 1'b0; set_leof = 1'b0;
    lwin_d = lwin_rd_q; lpkt_d = lpkt_rd_q; pwin_d = pwin_rd_q;
    inc_used = 1'b0; dec_used = 1'b0;
    case (req_q.func)
      FN_L_OPEN: begin
        if (!free_ok_q) r0.status = RS_FULL;
        else begin
          wr_state = 1'b1; new_state = EST_PENDING; inc_used = 1'b1;
          wr_lwin = 1'b1; lwin_d = req_q.window;
          wr_lpkt = 1'b1; lpkt_d = req_q.max_packet;
          wr_peer = 1'b1; wr_pwin = 1'b1; pwin_d = '0;
          r0.action = AC_SEND_OPEN; r0.local_id = eid;
          r0.value_a = req_q.window; r0.value_b = req_q.max_packet;
        end
      end
      FN_L_WRITE: begin
        if (!hit_q || st != EST_OPEN || leof_q[ent]) r0.status = RS_INVAL;
        else if (pwin_rd_q < req_q.amount || {1'b0, ppkt_rd_q} < need)
          r0.status = RS_LARGE;
        else begin
          wr_pwin = 1'b1; pwin_d = pwin_rd_q - req_q.amount;
          r0.action = AC_SEND_DATA; r0.local_id = eid;
          r0.remote_id = pnum_rd_q; r0.value_a = req_q.amount;
        end
      end
      FN_L_ADJUST: begin
        if (!hit_q || !oc) r0.status = RS_INVAL;
        else begin
          wr_lwin = 1'b1; lwin_d = lwin_rd_q + req_q.amount;
          r0.action = AC_SEND_ADJUST; r0.local_id = eid;
          r0.remote_id = pnum_rd_q; r0.value_a = req_q.amount;
        end
      end
      FN_L_EOF: begin
        if (!hit_q || !oc || leof_q[ent]) r0.status = RS_INVAL;
        else begin
          set_leof = 1'b1;
          r0.action = AC_SEND_EOF; r0.local_id = eid; r0.remote_id = pnum_rd_q;
        end
      end
      FN_L_CLOSE: begin
        if (!hit_q || st != EST_OPEN) r0.status = RS_INVAL;
        else begin
          wr_state = 1'b1; new_state = EST_CLOSED;
          r0.action = AC_SEND_CLOSE; r0.local_id = eid; r0.remote_id = pnum_rd_q;
        end
      end
      FN_R_OPEN: begin
        r0.action = AC_SEND_FAIL; r0.remote_id = req_q.peer_id;
        if (!req_q.type_known) r0.value_a = REASON_UNKNOWN_TYPE;
        else if (!free_ok_q) r0.value_a = REASON_SHORTAGE;
        else if (!req_q.accepted) r0.value_a = REASON_PROHIBITED;
        else begin
          wr_state = 1'b1; new_state = EST_OPEN; inc_used = 1'b1;
          wr_lwin = 1'b1; lwin_d = defwin_q;
          wr_lpkt = 1'b1; lpkt_d = defpkt_q;
          wr_peer = 1'b1; wr_pwin = 1'b1; pwin_d = req_q.window;
          r0.action = AC_SEND_CONFIRM; r0.local_id = eid;
          r0.value_a = defwin_q; r0.value_b = defpkt_q;
        end
      end
      FN_R_CONF: begin
        if (!hit_q || st != EST_PENDING) r0.status = RS_IGNORED;
        else begin
          wr_state = 1'b1; new_state = EST_OPEN;
          wr_peer = 1'b1; wr_pwin = 1'b1; pwin_d = req_q.window;
          r0.action = AC_NOTE_OPEN; r0.local_id = eid;
          two = (req_q.window != '0);
          r1.action = AC_NOTE_WINDOW; r1.local_id = eid; r1.value_a = req_q.window;
        end
      end
      FN_R_FAIL: begin
        if (!hit_q || st != EST_PENDING) r0.status = RS_IGNORED;
        else begin
          wr_state = 1'b1; new_state = EST_FREE; dec_used = 1'b1;
          r0.action = AC_NOTE_OPEN; r0.local_id = eid; r0.value_a = req_q.amount;
        end
      end
      FN_R_ADJUST: begin
        if (!hit_q || !oc) r0.status = RS_IGNORED;
        else begin
          wr_pwin = 1'b1; pwin_d = pwin_rd_q + req_q.amount;
          r0.action = AC_NOTE_WINDOW; r0.local_id = eid; r0.value_a = pwin_d;
        end
      end
      FN_R_DATA: begin
        if (!hit_q || !oc || peof_q[ent] || lwin_rd_q < req_q.amount
            || {1'b0, lpkt_rd_q} < need) r0.status = RS_IGNORED;
        else begin
          wr_lwin = 1'b1; lwin_d = lwin_rd_q - req_q.amount;
          r0.action = AC_NOTE_DATA; r0.local_id = eid; r0.value_a = req_q.amount;
        end
      end
      FN_R_EOF: begin
        if (!hit_q || !oc || peof_q[ent]) r0.status = RS_IGNORED;
        else begin
          set_peof = 1'b1;
          r0.action = AC_NOTE_EOF; r0.local_id = eid;
        end
      end
      FN_R_CLOSE: begin
        if (!hit_q) r0.status = RS_IGNORED;
        else begin
          wr_state = 1'b1; new_state = EST_FREE; dec_used = 1'b1;
          r1.action = AC_NOTE_CLOSE; r1.local_id = eid;
          if (st != EST_CLOSED) begin
            two = 1'b1;
            r0.action = AC_SEND_CLOSE; r0.local_id = eid; r0.remote_id = pnum_rd_q;
          end else begin
            r0 = r1;
          end
        end
      end
      default: r0.status = RS_IGNORED;
    endcase
    r0.last = !two;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res0_q <= r0;
      res1_q <= r1;
      if (wr_lwin) lwin_mem[ent] <= lwin_d;
      if (wr_lpkt) lpkt_mem[ent] <= lpkt_d;
      if (wr_peer) pnum_mem[ent] <= req_q.func == FN_L_OPEN ? '0 : req_q.peer_id;
      if (wr_pwin) pwin_mem[ent] <= pwin_d;
      if (wr_peer) ppkt_mem[ent] <= req_q.func == FN_L_OPEN ? '0 : req_q.max_packet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) state_q[i] <= EST_FREE;
      peof_q   <= '0;
      leof_q   <= '0;
      used_q   <= '0;
      two_q    <= 1'b0;
      defwin_q <= DefWindowReset;
      defpkt_q <= DefMaxPktReset;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DEF_WINDOW) defwin_q <= cfg_data_i;
        else defpkt_q <= cfg_data_i;
      end
      if (cmd_i.execute) begin
        two_q <= two;
        if (wr_state) state_q[ent] <= new_state;
        if (inc_used) begin
          peof_q[ent] <= 1'b0;
          leof_q[ent] <= 1'b0;
          used_q <= used_q + 1'b1;
        end
        if (dec_used && used_q != '0) used_q <= used_q - 1'b1;
        if (set_peof) peof_q[ent] <= 1'b1;
        if (set_leof) leof_q[ent] <= 1'b1;
      end
    end
  end

  assign sts_o.two_results = two_q;
  assign res_o = cmd_i.sel_second ? res1_q : res0_q;

endmodule

// ----- src/sctfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// SSH channel table controller
// Sequences load, read, execute and result delivery for one request.
// ----------------------------------------------------------------------------
module sctfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sctfc_pkg::dp_cmd_t  cmd_o,
  input  sctfc_pkg::dp_sts_t  sts_i
);
  import sctfc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_OUT0 = 3'd3;
  localparam logic [2:0] S_OUT1 = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read_ent = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = S_OUT0;
      end
      S_OUT0: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = sts_i.two_results ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        out_valid_o = 1'b1;
        cmd_o.sel_second = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ----- src/ssh_channel_table_flow_control.sv -----
// ----------------------------------------------------------------------------
// SSH channel table with window flow control
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// One request is handled at a time. An accepted transfer is captured, the
// addressed or lowest free entry is read from the table memories, and the
// request is executed; the controller steps through its read and execute
// states before the first result is offered, and a second result follows
// once the first is taken. Configuration writes are taken in any cycle.
module ssh_channel_table_flow_control (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[3:0], chan_id[35:4], peer_id[67:36], window[99:68],
  // max_packet[131:100], amount[163:132], type_known[164], accepted[165]
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], action[6:3], local_id[14:7], remote_id[46:15],
  // value_a[78:47], value_b[110:79]
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import sctfc_pkg::*;

  req_t     req;
  res_t     res;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  assign req.func       = s_axis_tdata[3:0];
  assign req.chan_id    = s_axis_tdata[35:4];
  assign req.peer_id    = s_axis_tdata[67:36];
  assign req.window     = s_axis_tdata[99:68];
  assign req.max_packet = s_axis_tdata[131:100];
  assign req.amount     = s_axis_tdata[163:132];
  assign req.type_known = s_axis_tdata[164];
  assign req.accepted   = s_axis_tdata[165];

  assign cfg_ready_o = 1'b1;

  sctfc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sctfc_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i      (req),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  assign m_axis_tdata = {1'b0, res.value_b, res.value_a, res.remote_id,
                         res.local_id, res.action, res.status};
  assign m_axis_tlast = res.last;

endmodule

// ----- src/sctfc_checker.sv -----
// ----------------------------------------------------------------------------
// SSH channel table port checker
// Port-level properties of the channel table, bound to the top level.
// ----------------------------------------------------------------------------
module sctfc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  // The block takes no new request while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result offered");

  // The first result follows a transfer in once the read and execute states have passed.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##2 m_axis_tvalid)
    else $error("result latency wrong");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A final result returns the block to accepting requests.
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final result");

endmodule

bind ssh_channel_table_flow_control sctfc_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel table testbench
// Drives requests and received messages into the channel table, predicts each
// result from a behavioural copy of the table and checks every output transfer.
// ----------------------------------------------------------------------------

import sctfc_pkg::*;

class channel_scoreboard;
  logic [2:0]  ent_state [NumChannels];
  logic        peer_eof  [NumChannels];
  logic        our_eof   [NumChannels];
  logic [31:0] our_win   [NumChannels];
  logic [31:0] our_pkt   [NumChannels];
  logic [31:0] peer_num  [NumChannels];
  logic [31:0] peer_win  [NumChannels];
  logic [31:0] peer_pkt  [NumChannels];
  logic [31:0] dflt_win;
  logic [31:0] dflt_pkt;
  res_t        pending_results [$];
  int          error_count;

  function new();
    dflt_win = DefWindowReset;
    dflt_pkt = DefMaxPktReset;
    error_count = 0;
    for (int i = 0; i < NumChannels; i++) begin
      ent_state[i] = EST_FREE;
      peer_eof[i] = 0;
      our_eof[i] = 0;
    end
  endfunction

  function void set_register(logic idx, logic [31:0] val);
    if (idx == CFG_DEF_WINDOW) dflt_win = val;
    else dflt_pkt = val;
  endfunction

  function int lookup(logic [31:0] id);
    if (id >= NumChannels) return -1;
    if (ent_state[id] == EST_FREE) return -1;
    return int'(id);
  endfunction

  function int allocate();
    for (int i = 0; i < NumChannels; i++)
      if (ent_state[i] == EST_FREE) begin
        ent_state[i] = EST_ALLOC;
        peer_eof[i] = 0; our_eof[i] = 0;
        our_win[i] = 0; our_pkt[i] = 0;
        peer_num[i] = 0; peer_win[i] = 0; peer_pkt[i] = 0;
        return i;
      end
    return -1;
  endfunction

  function void push(logic [2:0] st, logic [3:0] ac, int lid, logic [31:0] rid,
                     logic [31:0] a, logic [31:0] b);
    res_t r;
    r.status = st; r.action = ac; r.local_id = lid[7:0];
    r.remote_id = rid; r.value_a = a; r.value_b = b; r.last = 0;
    pending_results.push_back(r);
  endfunction

  function bit live(int e);
    return ent_state[e] == EST_OPEN || ent_state[e] == EST_CLOSED;
  endfunction

  // Works out the results of one accepted request and updates the table.
  function void note_request(req_t q);
    int e;
    logic [32:0] need;
    need = {1'b0, q.amount} + PktOverhead;
    e = -1;
    case (q.func)
      FN_L_OPEN: begin
        e = allocate();
        if (e < 0) push(RS_FULL, AC_NONE, 0, 0, 0, 0);
        else begin
          ent_state[e] = EST_PENDING;
          our_win[e] = q.window; our_pkt[e] = q.max_packet;
          push(RS_OK, AC_SEND_OPEN, e, 0, q.window, q.max_packet);
        end
      end
      FN_L_WRITE: begin
        e = lookup(q.chan_id);
        if (e < 0 || ent_state[e] != EST_OPEN || our_eof[e])
          push(RS_INVAL, AC_NONE, 0, 0, 0, 0);
        else if (peer_win[e] < q.amount || {1'b0, peer_pkt[e]} < need)
          push(RS_LARGE, AC_NONE, 0, 0, 0, 0);
        else begin
          peer_win[e] -= q.amount;
          push(RS_OK, AC_SEND_DATA, e, peer_num[e], q.amount, 0);
        end
      end
      FN_L_ADJUST: begin
        e = lookup(q.chan_id);
        if (e < 0 || !live(e)) push(RS_INVAL, AC_NONE, 0, 0, 0, 0);
        else begin
          our_win[e] += q.amount;
          push(RS_OK, AC_SEND_ADJUST, e, peer_num[e], q.amount, 0);
        end
      end
      FN_L_EOF: begin
        e = lookup(q.chan_id);
        if (e < 0 || !live(e) || our_eof[e]) push(RS_INVAL, AC_NONE, 0, 0, 0, 0);
        else begin
          our_eof[e] = 1;
          push(RS_OK, AC_SEND_EOF, e, peer_num[e], 0, 0);
        end
      end
      FN_L_CLOSE: begin
        e = lookup(q.chan_id);
        if (e < 0 || ent_state[e] != EST_OPEN) push(RS_INVAL, AC_NONE, 0, 0, 0, 0);
        else begin
          ent_state[e] = EST_CLOSED;
          push(RS_OK, AC_SEND_CLOSE, e, peer_num[e], 0, 0);
        end
      end
      FN_R_OPEN: begin
        if (!q.type_known) push(RS_OK, AC_SEND_FAIL, 0, q.peer_id, REASON_UNKNOWN_TYPE, 0);
        else begin
          e = allocate();
          if (e < 0) push(RS_OK, AC_SEND_FAIL, 0, q.peer_id, REASON_SHORTAGE, 0);
          else if (!q.accepted) begin
            ent_state[e] = EST_FREE;
            push(RS_OK, AC_SEND_FAIL, 0, q.peer_id, REASON_PROHIBITED, 0);
          end else begin
            ent_state[e] = EST_OPEN;
            our_win[e] = dflt_win; our_pkt[e] = dflt_pkt;
            peer_num[e] = q.peer_id; peer_win[e] = q.window; peer_pkt[e] = q.max_packet;
            push(RS_OK, AC_SEND_CONFIRM, e, q.peer_id, dflt_win, dflt_pkt);
          end
        end
      end
      FN_R_CONF: begin
        e = lookup(q.chan_id);
        if (e < 0 || ent_state[e] != EST_PENDING) push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          peer_num[e] = q.peer_id; peer_win[e] = q.window; peer_pkt[e] = q.max_packet;
          ent_state[e] = EST_OPEN;
          push(RS_OK, AC_NOTE_OPEN, e, 0, 0, 0);
          if (q.window != 0) push(RS_OK, AC_NOTE_WINDOW, e, 0, q.window, 0);
        end
      end
      FN_R_FAIL: begin
        e = lookup(q.chan_id);
        if (e < 0 || ent_state[e] != EST_PENDING) push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          push(RS_OK, AC_NOTE_OPEN, e, 0, q.amount, 0);
          ent_state[e] = EST_FREE;
        end
      end
      FN_R_ADJUST: begin
        e = lookup(q.chan_id);
        if (e < 0 || !live(e)) push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          peer_win[e] += q.amount;
          push(RS_OK, AC_NOTE_WINDOW, e, 0, peer_win[e], 0);
        end
      end
      FN_R_DATA: begin
        e = lookup(q.chan_id);
        if (e < 0 || !live(e) || peer_eof[e] || our_win[e] < q.amount ||
            {1'b0, our_pkt[e]} < need)
          push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          our_win[e] -= q.amount;
          push(RS_OK, AC_NOTE_DATA, e, 0, q.amount, 0);
        end
      end
      FN_R_EOF: begin
        e = lookup(q.chan_id);
        if (e < 0 || !live(e) || peer_eof[e]) push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          peer_eof[e] = 1;
          push(RS_OK, AC_NOTE_EOF, e, 0, 0, 0);
        end
      end
      FN_R_CLOSE: begin
        e = lookup(q.chan_id);
        if (e < 0) push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
        else begin
          if (ent_state[e] != EST_CLOSED) push(RS_OK, AC_SEND_CLOSE, e, peer_num[e], 0, 0);
          push(RS_OK, AC_NOTE_CLOSE, e, 0, 0, 0);
          ent_state[e] = EST_FREE;
        end
      end
      default: push(RS_IGNORED, AC_NONE, 0, 0, 0, 0);
    endcase
    pending_results[$].last = 1;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transfer %h", $realtime, got);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.action !== want.action) report("action", got.action, want.action);
    if (got.local_id !== want.local_id) report("local_id", got.local_id, want.local_id);
    if (got.remote_id !== want.remote_id) report("remote_id", got.remote_id, want.remote_id);
    if (got.value_a !== want.value_a) report("value_a", got.value_a, want.value_a);
    if (got.value_b !== want.value_b) report("value_b", got.value_b, want.value_b);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask
endclass

module tb_top;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 0;
  logic [31:0]  cfg_data_i = '0;

  channel_scoreboard table_model = new();
  bit sink_busy_mode = 1;

  ssh_channel_table_flow_control DUT (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  task write_register(logic idx, logic [31:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    table_model.set_register(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // The valid line is left high after a transfer so that a request with no
  // gap follows at once; it is dropped when a gap is drawn or the bench drains.
  task send_request(req_t q);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, q.accepted, q.type_known, q.amount, q.max_packet,
                     q.window, q.peer_id, q.chan_id, q.func};
    do @(posedge clk_i); while (!s_axis_tready);
    table_model.note_request(q);
  endtask

  function req_t make_req(logic [3:0] f, logic [31:0] cid);
    req_t q;
    q.func = f; q.chan_id = cid;
    q.peer_id = $urandom; q.window = $urandom; q.max_packet = $urandom;
    q.amount = $urandom_range(0, 4000);
    q.type_known = 1; q.accepted = 1;
    return q;
  endfunction

  task drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (table_model.pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i); guard++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  // Result sink: random stalls per transfer, with stretches of constant ready.
  initial begin
    int stall;
    res_t got_r;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.status    = m_axis_tdata[2:0];
        got_r.action    = m_axis_tdata[6:3];
        got_r.local_id  = m_axis_tdata[14:7];
        got_r.remote_id = m_axis_tdata[46:15];
        got_r.value_a   = m_axis_tdata[78:47];
        got_r.value_b   = m_axis_tdata[110:79];
        got_r.last      = m_axis_tlast;
        table_model.check_result(got_r);
      end
      if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        stall = sink_busy_mode ? $urandom_range(0, 9) : 0;
        if (stall != 0 && m_axis_tready) m_axis_tready <= 0;
        else if (stall == 0) m_axis_tready <= 1;
        else begin
          repeat (stall - 1) @(posedge clk_i);
          m_axis_tready <= 1;
        end
      end
    end
  end

  initial begin
    req_t q;
    int ch;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_register(CFG_DEF_WINDOW, 32'hFFFF_FFFF);
    write_register(CFG_DEF_MAX_PKT, 32'd0);

    // Directed part: open/confirm, peer open, credit limits, eof, closes.
    q = make_req(FN_L_OPEN, 0); q.window = 32'hFFFF_FFFF; q.max_packet = 32'd10;
    send_request(q);
    q = make_req(FN_R_CONF, 0); q.window = 32'd5; q.max_packet = 32'hFFFF_FFFF;
    send_request(q);
    q = make_req(FN_L_WRITE, 0); q.amount = 32'd6; send_request(q);
    q = make_req(FN_L_WRITE, 0); q.amount = 32'd5; send_request(q);
    q = make_req(FN_R_ADJUST, 0); q.amount = 32'hFFFF_FFFF; send_request(q);
    q = make_req(FN_L_WRITE, 0); q.amount = 32'hFFFF_FFFB; send_request(q);
    q = make_req(FN_R_DATA, 0); q.amount = 32'd6; send_request(q);
    q = make_req(FN_R_DATA, 0); q.amount = 32'd5; send_request(q);
    q = make_req(FN_L_ADJUST, 0); q.amount = 32'hFFFF_FFFF; send_request(q);
    q = make_req(FN_L_OPEN, 0); q.window = 0; send_request(q);
    q = make_req(FN_R_CONF, 1); q.window = 0; send_request(q);
    q = make_req(FN_L_OPEN, 0); send_request(q);
    q = make_req(FN_R_FAIL, 2); q.amount = 32'hFFFF_FFFF; send_request(q);
    q = make_req(FN_R_OPEN, 0); q.type_known = 0; send_request(q);
    q = make_req(FN_R_OPEN, 0); q.accepted = 0; send_request(q);
    q = make_req(FN_R_OPEN, 0); q.peer_id = 32'hFFFF_FFFF; send_request(q);
    q = make_req(FN_L_EOF, 0); send_request(q);
    q = make_req(FN_L_EOF, 0); send_request(q);
    q = make_req(FN_R_EOF, 0); send_request(q);
    q = make_req(FN_L_CLOSE, 0); send_request(q);
    q = make_req(FN_R_CLOSE, 0); send_request(q);
    q = make_req(FN_R_CLOSE, 1); send_request(q);
    q = make_req(FN_L_WRITE, 32'hFFFF_FFFF); send_request(q);
    q = make_req(FN_R_DATA, 32'd16); send_request(q);
    q = make_req(4'd15, 0); send_request(q);
    drain();
    write_register(CFG_DEF_WINDOW, 32'd0);
    write_register(CFG_DEF_MAX_PKT, 32'hFFFF_FFFF);

    // Random part: mostly requests on in-range channels, some noise.
    for (int n = 0; n < 950; n++) begin
      if (n % 240 == 120) begin
        drain();
        write_register(CFG_DEF_WINDOW, $urandom);
        write_register(CFG_DEF_MAX_PKT, $urandom_range(0, 1) ? $urandom : 32'd20000);
        sink_busy_mode = $urandom_range(0, 1);
      end
      ch = $urandom_range(0, NumChannels - 1);
      q = make_req(4'($urandom_range(0, 11)), 32'(ch));
      case ($urandom_range(0, 19))
        0: q.func = 4'($urandom_range(12, 15));
        1: q.chan_id = $urandom;
        2: q.amount = $urandom;
        3: begin q.type_known = 1'($urandom); q.accepted = 1'($urandom); end
        4: begin q.window = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF; end
        default: ;
      endcase
      if (q.func == FN_R_OPEN || q.func == FN_R_CONF) begin
        if ($urandom_range(0, 1)) q.max_packet = $urandom_range(4000, 70000);
        if ($urandom_range(0, 1)) q.window = $urandom_range(0, 100000);
      end
      // Keep the table from filling for too long.
      if (q.func == FN_L_OPEN && $urandom_range(0, 2) == 0) q.func = FN_R_CLOSE;
      send_request(q);
    end
    drain();
    if (table_model.error_count == 0 && table_model.pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
